// ----- hw/rtl/pee_pkg.sv -----
// Package for the postfix expression evaluator.
// Holds the command format between front and back, status codes and character codes.
// No dependencies.
package pee_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] CHR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHR_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CHR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHR_STAR  = 8'h2A;  // '*'

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVERFLOW,
        ST_UNDERFLOW,
        ST_INCOMPLETE
    } t_status;

    typedef struct packed {
        t_op        op;
        logic [3:0] value;   // digit value for a push
        logic       last;    // final character of the expression
    } t_cmd;

endpackage

// ----- hw/rtl/postfix_expression_evaluator.sv -----
// Postfix expression evaluator, top level.
// Depends on pee_pkg, pee_front, pee_queue, pee_back.
//
// Takes a postfix expression one character per transfer on the slave stream
// (tlast marks the final character) and gives one result per expression on
// the master stream. Digits '0'..'9' push their value, '+', '-' and '*' pop
// two operands and push (second op first) wrapped to 8 bits; every other
// character is ignored. Status: 0 ok, 1 overflow (push on a full stack),
// 2 underflow (operator with fewer than two operands, or empty stack at the
// end), 3 incomplete (operands left below the top). The first error freezes
// the stack until the end of the expression; on an error the answer is 0.
// After each result the stack is empty again, with no dead cycles.
// Throughput: one character per clock. A character is written into the
// two-entry queue at its transfer and executes on the stack at the next clock
// edge at the earliest; the result register loads at that same edge, so a
// result is valid once the final character has executed. The stack is a
// shift register with the top entry in a fixed place, so a push or a
// pop-pop-push completes as its character executes. The input keeps flowing
// while a result waits on the output, until the queue fills.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pee_pkg::DEF_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] character
    input  logic        i_s_axis_tlast,   // last_char
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [7:0] answer, [9:8] status, [15:10] zero
);
    import pee_pkg::*;

    // decoded command stream: front -> queue -> back
    t_cmd       w_fr_cmd;
    logic       w_fr_valid, w_fr_ready;
    t_cmd       w_bk_cmd;
    logic       w_bk_valid, w_bk_ready;
    logic [7:0] w_answer;
    logic [1:0] w_status;

    pee_front u_front (
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_char      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_cmd_valid (w_fr_valid),
        .i_cmd_ready (w_fr_ready),
        .o_cmd       (w_fr_cmd)
    );

    pee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fr_valid),
        .o_wr_ready (w_fr_ready),
        .i_wr_cmd   (w_fr_cmd),
        .o_rd_valid (w_bk_valid),
        .i_rd_ready (w_bk_ready),
        .o_rd_cmd   (w_bk_cmd)
    );

    pee_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_bk_valid),
        .o_cmd_ready (w_bk_ready),
        .i_cmd       (w_bk_cmd),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_answer    (w_answer),
        .o_status    (w_status)
    );

    assign o_m_axis_tdata = {6'b0, w_status, w_answer};

endmodule

// ----- hw/rtl/pee_front.sv -----
// Front end: accepts characters and decodes them into stack commands.
// Depends on pee_pkg.
module pee_front (
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output pee_pkg::t_cmd o_cmd
);
    import pee_pkg::*;

    t_op w_op;

    always_comb begin
        w_op = OP_NONE;
        if (i_char >= CHR_ZERO && i_char <= CHR_NINE) begin
            w_op = OP_PUSH;
        end else begin
            unique case (i_char)
                CHR_PLUS:  w_op = OP_ADD;
                CHR_MINUS: w_op = OP_SUB;
                CHR_STAR:  w_op = OP_MUL;
                default:   w_op = OP_NONE;
            endcase
        end
    end

    assign o_cmd.op    = w_op;
    assign o_cmd.value = 4'(i_char - CHR_ZERO);
    assign o_cmd.last  = i_last;

    assign o_cmd_valid = i_s_valid;
    assign o_s_ready   = i_cmd_ready;

endmodule

// ----- hw/rtl/pee_queue.sv -----
// Short command queue between front end and back end.
// Depends on pee_pkg.
module pee_queue #(
    parameter int DEPTH = pee_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  pee_pkg::t_cmd i_wr_cmd,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output pee_pkg::t_cmd o_rd_cmd
);
    import pee_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wr, w_rd;

    assign o_wr_ready = (r_cnt != CW'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

// ----- hw/rtl/pee_back.sv -----
// Back end: operand stack as a shift register, ALU, and result register.
// Depends on pee_pkg.
module pee_back #(
    parameter int STACK_DEPTH = pee_pkg::DEF_STACK_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  pee_pkg::t_cmd i_cmd,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output logic [7:0]    o_answer,
    output logic [1:0]    o_status
);
    import pee_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    // entry 0 is the top of stack
    logic [7:0]    r_stk [STACK_DEPTH];
    logic [7:0]    n_stk [STACK_DEPTH];
    logic [CW-1:0] r_count, n_count;
    t_status       r_err, n_err;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_answer, n_answer;
    t_status       r_status, n_status;

    logic          w_exec;
    logic          w_push, w_alu;
    logic [7:0]    w_alu_res;
    logic [15:0]   w_prod;

    assign o_cmd_ready = !r_out_valid || i_res_ready;
    assign w_exec      = i_cmd_valid && o_cmd_ready;

    assign w_prod = 16'(r_stk[1]) * 16'(r_stk[0]);

    always_comb begin
        unique case (i_cmd.op)
            OP_ADD:  w_alu_res = r_stk[1] + r_stk[0];
            OP_SUB:  w_alu_res = r_stk[1] - r_stk[0];
            OP_MUL:  w_alu_res = w_prod[7:0];
            default: w_alu_res = r_stk[0];
        endcase
    end

    always_comb begin
        w_push  = 1'b0;
        w_alu   = 1'b0;
        n_err   = r_err;
        n_count = r_count;
        if (w_exec && r_err == ST_OK) begin
            case (i_cmd.op)
                OP_PUSH: begin
                    if (r_count >= CW'(STACK_DEPTH)) begin
                        n_err = ST_OVERFLOW;
                    end else begin
                        w_push  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                OP_ADD, OP_SUB, OP_MUL: begin
                    if (r_count < CW'(2)) begin
                        n_err = ST_UNDERFLOW;
                    end else begin
                        w_alu   = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_stk[0] = w_push ? {4'b0, i_cmd.value} : (w_alu ? w_alu_res : r_stk[0]);
        for (int i = 1; i < STACK_DEPTH - 1; i++) begin
            n_stk[i] = w_push ? r_stk[i-1] : (w_alu ? r_stk[i+1] : r_stk[i]);
        end
        n_stk[STACK_DEPTH-1] = w_push ? r_stk[STACK_DEPTH-2] : r_stk[STACK_DEPTH-1];
    end

    // end of expression: report from the state after this character
    always_comb begin
        n_out_valid = r_out_valid && !i_res_ready;
        n_answer    = r_answer;
        n_status    = r_status;
        if (w_exec && i_cmd.last) begin
            n_out_valid = 1'b1;
            if (n_err != ST_OK) begin
                n_answer = '0;
                n_status = n_err;
            end else if (n_count == '0) begin
                n_answer = '0;
                n_status = ST_UNDERFLOW;
            end else begin
                n_answer = n_stk[0];
                n_status = (n_count != CW'(1)) ? ST_INCOMPLETE : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_exec && i_cmd.last) begin
                r_count <= '0;
                r_err   <= ST_OK;
            end else begin
                r_count <= n_count;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stk    <= n_stk;
        r_answer <= n_answer;
        r_status <= n_status;
    end

    assign o_res_valid = r_out_valid;
    assign o_answer    = r_answer;
    assign o_status    = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && i_cmd.last) |=> (r_count == '0 && r_err == ST_OK && r_out_valid))
        else $error("end of expression did not clear stack or post result");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ST_INCOMPLETE)
        else $error("sticky error holds incomplete code");

    a_err_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_OVERFLOW || r_status == ST_UNDERFLOW))
            |-> (r_answer == '0))
        else $error("error result carries nonzero answer");

    a_err_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK && !(w_exec && i_cmd.last)) |=> ($stable(r_count)))
        else $error("stack moved after an error");

endmodule

// ----- dv/postfix_expression_evaluator_tb.sv -----
// Testbench for postfix_expression_evaluator: directed and random postfix expressions
// on the character stream, checked against an in-bench stack model result by result.
// Depends on pee_pkg and the evaluator RTL.
`timescale 1ns / 1ps

module postfix_expression_evaluator_tb;
    import pee_pkg::*;

    localparam int DEPTH      = DEF_STACK_DEPTH;
    localparam int IDLE_LIMIT = 1000;  // cycles with no transfer on either side
    localparam int TAIL       = 20;    // settle time after the last result
    localparam int RAND_ITEMS = 500;

    // one expected result: popped top and status
    typedef struct packed {
        logic [7:0] answer;
        t_status    status;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] character
    logic        i_s_axis_tlast = 1'b0;    // last_char
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;           // [7:0] answer, [9:8] status, [15:10] zero

    postfix_expression_evaluator #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Stack model state, mirrors the evaluator between expressions
    logic [7:0] operand_mem [DEPTH];
    int         operand_cnt = 0;
    t_status    expr_error = ST_OK;

    t_result    pending_answers [$];   // results owed by the block, oldest first
    logic [7:0] expr_chars [$];        // expression being built for sending

    int err_count       = 0;
    int chars_sent      = 0;
    int exprs_sent      = 0;
    int results_checked = 0;
    int status_seen [4] = '{default: 0};

    // idle/stall enables, toggled per expression to get both busy and quiet stretches
    bit tx_idle_on = 1'b1;
    bit rx_stall_on = 1'b1;

    // Model one accepted character. Errors freeze the stack until the last
    // character; the last character pops the top and closes out the expression.
    function automatic void evaluate_char(logic [7:0] c, logic lst);
        t_result    res;
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] value;
        if (expr_error == ST_OK) begin
            if (c >= CHR_ZERO && c <= CHR_NINE) begin
                if (operand_cnt >= DEPTH) begin
                    expr_error = ST_OVERFLOW;
                end else begin
                    operand_mem[operand_cnt] = c - CHR_ZERO;
                    operand_cnt++;
                end
            end else if (c == CHR_PLUS || c == CHR_MINUS || c == CHR_STAR) begin
                if (operand_cnt < 2) begin
                    expr_error = ST_UNDERFLOW;
                end else begin
                    first  = operand_mem[operand_cnt - 1];
                    second = operand_mem[operand_cnt - 2];
                    case (c)
                        CHR_PLUS:  value = second + first;
                        CHR_MINUS: value = second - first;
                        default:   value = second * first;   // wraps mod 256
                    endcase
                    operand_cnt--;
                    operand_mem[operand_cnt - 1] = value;
                end
            end
            // anything else is filler
        end
        if (lst) begin
            res.answer = 8'h00;
            if (expr_error != ST_OK) begin
                res.status = expr_error;
            end else if (operand_cnt == 0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                operand_cnt--;
                res.answer = operand_mem[operand_cnt];
                res.status = (operand_cnt != 0) ? ST_INCOMPLETE : ST_OK;
            end
            pending_answers.push_back(res);
            operand_cnt = 0;
            expr_error  = ST_OK;
            foreach (operand_mem[i]) operand_mem[i] = 8'h00;
        end
    endfunction

    // Sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int k;
        if (!tx_idle_on) return 0;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] pick_digit();
        return CHR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 2))
            0:       return CHR_PLUS;
            1:       return CHR_MINUS;
            default: return CHR_STAR;
        endcase
    endfunction

    // a byte that is neither a digit nor an operator
    function automatic logic [7:0] pick_filler();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while ((c >= CHR_ZERO && c <= CHR_NINE) ||
                   c == CHR_PLUS || c == CHR_MINUS || c == CHR_STAR);
        return c;
    endfunction

    // One character transfer; the model is updated at the accepting edge
    task automatic send_char(input logic [7:0] c, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_axis_tready);
        evaluate_char(c, lst);
        chars_sent++;
    endtask

    // Send the built expression, tlast on its final character
    task automatic send_expr();
        foreach (expr_chars[i]) send_char(expr_chars[i], i == expr_chars.size() - 1);
        expr_chars.delete();
        exprs_sent++;
    endtask

    task automatic load_text(input string s);
        foreach (s[i]) expr_chars.push_back(s[i]);
    endtask

    // Hold off the sender until every owed result has come back
    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
    endtask

    // --- test tasks ----------------------------------------------------------

    // plain arithmetic, negative difference, product wrap, filler in the middle
    task automatic test_arithmetic();
        load_text("34+");
        send_expr();
        expr_chars.push_back(CHR_ZERO + 8'd5);
        expr_chars.push_back(8'hFF);
        load_text("9-");                     // 5 - 9 = -4
        send_expr();
        load_text("99*9*");                  // 729 wraps to 217
        send_expr();
        load_text("00+");                    // all-zero operands
        send_expr();
    endtask

    // error statuses, ignore-after-error and leftover entries
    task automatic test_special_cases();
        load_text("+9");                     // operator on empty stack, rest ignored
        send_expr();
        expr_chars.push_back(8'h00);         // NUL alone: nothing to pop
        send_expr();
        repeat (DEPTH + 1) expr_chars.push_back(CHR_NINE);  // one push too many
        send_expr();
        load_text("12");                     // entry left under the top
        send_expr();
    endtask

    // well-formed expression with random content; long ones may overflow,
    // some are left unreduced on purpose
    task automatic build_wellformed();
        int n;
        int pushed;
        int depth;
        bit leave;
        n      = ($urandom_range(0, 9) == 0) ? $urandom_range(12, DEPTH + 2)
                                              : $urandom_range(1, 8);
        leave  = ($urandom_range(0, 4) == 0);
        pushed = 0;
        depth  = 0;
        forever begin
            if ($urandom_range(0, 9) == 0) expr_chars.push_back(pick_filler());
            if (pushed < n && (depth < 2 || $urandom_range(0, 1) == 1)) begin
                expr_chars.push_back(pick_digit());
                pushed++;
                depth++;
            end else if (depth >= 2 && !(leave && pushed == n)) begin
                expr_chars.push_back(pick_operator());
                depth--;
            end else begin
                break;
            end
        end
    endtask

    // arbitrary bytes, biased toward digits and operators
    task automatic build_noise();
        int len;
        int k;
        len = $urandom_range(1, 10);
        repeat (len) begin
            k = $urandom_range(0, 9);
            if (k < 4)      expr_chars.push_back(pick_digit());
            else if (k < 7) expr_chars.push_back(pick_operator());
            else            expr_chars.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_streams();
        int start_chars;
        start_chars = chars_sent;
        while (chars_sent - start_chars < RAND_ITEMS) begin
            tx_idle_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7) build_wellformed();
            else                          build_noise();
            send_expr();
            if ($urandom_range(0, 29) == 0) wait_results_drained();
        end
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // --- result side: random stalls plus the check of each result ----------

    int stall_left = 0;

    always @(posedge i_clk) begin
        t_result    exp_r;
        logic [7:0] got_answer;
        t_status    got_status;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_answer = o_m_axis_tdata[7:0];
                got_status = t_status'(o_m_axis_tdata[9:8]);
                if (pending_answers.size() == 0) begin
                    $error("unexpected result: answer %0d status %s",
                           $signed(got_answer), got_status.name());
                    err_count++;
                end else begin
                    exp_r = pending_answers.pop_front();
                    results_checked++;
                    status_seen[exp_r.status]++;
                    if (got_answer !== exp_r.answer) begin
                        $error("answer: expected %0d, got %0d",
                               $signed(exp_r.answer), $signed(got_answer));
                        err_count++;
                    end
                    if (got_status !== exp_r.status) begin
                        $error("status: expected %s, got %s",
                               exp_r.status.name(), got_status.name());
                        err_count++;
                    end
                end
            end
            // back-pressure: mostly ready, short stalls, now and then a long one
            if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // --- watchdog: ends a run that stops moving ------------------------------

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles, %0d results owed",
                         IDLE_LIMIT, pending_answers.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // --- sequence ------------------------------------------------------------

    initial begin
        foreach (operand_mem[i]) operand_mem[i] = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_arithmetic();
        test_special_cases();
        wait_results_drained();
        test_random_streams();

        wait_results_drained();
        repeat (TAIL) @(posedge i_clk);

        $display("Covered %0d characters in %0d expressions; %0d results checked",
                 chars_sent, exprs_sent, results_checked);
        $display("by status ok/overflow/underflow/incomplete: %0d/%0d/%0d/%0d",
                 status_seen[ST_OK], status_seen[ST_OVERFLOW],
                 status_seen[ST_UNDERFLOW], status_seen[ST_INCOMPLETE]);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
